// File: rtl/core/optical_drive_command_controller_top_assert.svh
// Assertion macros used by the drive controller top module.
`ifndef OPTICAL_DRIVE_COMMAND_CONTROLLER_TOP_ASSERT_SVH
`define OPTICAL_DRIVE_COMMAND_CONTROLLER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ODC_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ODC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

// File: rtl/core/odcc_pkg.sv
// Package with shared types and constants of the drive controller.
`timescale 1ns / 1ps
package odcc_pkg;
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_DISK  = 2'd3;

    localparam logic [1:0] OFF_INDEX = 2'd0;
    localparam logic [1:0] OFF_CMD   = 2'd1;
    localparam logic [1:0] OFF_DATA  = 2'd2;
    localparam logic [1:0] OFF_IRQ   = 2'd3;

    localparam logic CFG_DISK_PRESENT = 1'b0;
    localparam logic CFG_IMAGE_BYTES  = 1'b1;

    localparam logic [7:0] STATUS_BYTE = 8'h02;
    localparam logic [7:0] ID_BYTE     = 8'h20;
    localparam logic [7:0] TEST_PARAM  = 8'h20;
    localparam logic [4:0] IRQ_ACK     = 5'h03;
    localparam logic [4:0] IRQ_MASK    = 5'h1F;

    localparam int          USER_BYTES = 2048;
    localparam int          BUF_AW     = 11;
    localparam logic [11:0] RAW_BYTES  = 12'd2352;
    localparam logic [4:0]  DATA_SKIP  = 5'd24;

    localparam logic [7:0] CMD_SETMODE  = 8'h0E;
    localparam logic [7:0] CMD_NOP      = 8'h01;
    localparam logic [7:0] CMD_GETID    = 8'h1A;
    localparam logic [7:0] CMD_GETID2   = 8'h02;
    localparam logic [7:0] CMD_READN    = 8'h06;
    localparam logic [7:0] CMD_READS    = 8'h1B;
    localparam logic [7:0] CMD_PAUSE    = 8'h09;
    localparam logic [7:0] CMD_INIT     = 8'h0A;
    localparam logic [7:0] CMD_GETPARAM = 8'h0F;
    localparam logic [7:0] CMD_GETTN    = 8'h13;
    localparam logic [7:0] CMD_GETTD    = 8'h14;
    localparam logic [7:0] CMD_TEST     = 8'h19;

    typedef enum logic [1:0] {
        DRV_IDLE    = 2'd0,
        DRV_READING = 2'd1,
        DRV_PAUSED  = 2'd2
    } drive_state_t;

    // Request from the controller to the sector buffer.
    typedef struct packed {
        logic             wr_en;
        logic [BUF_AW-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [BUF_AW-1:0] rd_addr;
    } buf_req_t;

    // Result held in the output stage.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_request;
        logic        fetch_valid;
        logic [31:0] fetch_offset;
    } result_t;
endpackage

// File: rtl/core/odcc_if.sv
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
interface odcc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [1:0]  reg_offset;
    logic [7:0]  write_value;
    logic [15:0] tick_cycles;
    logic [7:0]  disk_byte;
    modport source (output valid, mode, reg_offset, write_value, tick_cycles, disk_byte,
                    input ready);
    modport sink (input valid, mode, reg_offset, write_value, tick_cycles, disk_byte,
                  output ready);
endinterface

interface odcc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        irq_request;
    logic        fetch_valid;
    logic [31:0] fetch_offset;
    modport source (output valid, read_data, irq_request, fetch_valid, fetch_offset,
                    input ready);
    modport sink (input valid, read_data, irq_request, fetch_valid, fetch_offset,
                  output ready);
endinterface

// File: rtl/core/optical_drive_command_controller_top.sv
// Top level of the optical drive command controller.
`timescale 1ns / 1ps
`include "optical_drive_command_controller_top_assert.svh"
// Usage: items arrive on in_ch (valid/ready); each gives exactly one result on out_ch.
// Item kinds: register read, register write, tick and disk byte, chosen by mode.
// A read of the response FIFO or sector buffer uses a synchronous memory, so the
// read is issued when the item is accepted, the memory output is registered into
// the result in the memory-read state, and is offered in the output state.
// No new item is taken meanwhile: the block steps through accept, memory read and
// result transfer, and returns to accept once the result has been taken.
// The config port (cfg_we, cfg_index, cfg_data) writes disk_present and
// disk_image_bytes; write only while the block is idle.
// A tick completing a period while reading with a disk present requests the next
// sector if it is in range; the result then carries fetch_valid and the image offset.
// Reset clears all control state; the sector buffer holds no defined data
// until written, and no clearing pass is run.
// When the receiver stalls, the result stays in its register and no new item
// is accepted until it is taken.
module optical_drive_command_controller_top #(
    parameter int RESP_DEPTH  = 16,
    parameter int PARAM_DEPTH = 16,
    parameter int TICK_PERIOD = 1000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    odcc_in_if.sink     in_ch,
    odcc_out_if.source  out_ch
);
    localparam int PCW = $clog2(PARAM_DEPTH + 1);
    localparam int BW  = odcc_pkg::BUF_AW;

    typedef enum logic [1:0] { S_ACCEPT, S_MEM, S_OUT } ctl_state_t;
    typedef enum logic [1:0] { SRC_NONE, SRC_RESP, SRC_BUF } src_t;

    ctl_state_t              state_reg;
    logic                    disk_present_reg;
    logic [31:0]             image_bytes_reg;
    logic [1:0]              index_reg;
    logic [7:0]              param0_reg;
    logic [PCW-1:0]          param_count_reg;
    logic [4:0]              irq_flag_reg;
    odcc_pkg::drive_state_t  drive_reg;
    logic [31:0]             sector_reg;
    logic [31:0]             accum_reg;
    logic                    buf_full_reg;
    logic [BW:0]             buf_read_pos_reg;
    logic [BW-1:0]           fill_pos_reg;
    odcc_pkg::result_t       res_reg;
    src_t                    src_reg;

    logic                    accept;
    odcc_pkg::buf_req_t      breq;
    logic [7:0]              buf_rd;
    logic                    resp_load, resp_pop, resp_avail, id_reply;
    logic [3:0]              reply_len;
    logic [7:0]              resp_rd;
    logic                    known;
    logic [31:0]             accum_sum;
    logic [43:0]             base;
    logic                    in_range;
    logic                    tick_due;
    logic                    fetch_req;
    logic                    buf_avail;
    odcc_pkg::result_t       res_next;
    src_t                    src_next;

    assign accept = (state_reg == S_ACCEPT) && in_ch.valid;
    assign in_ch.ready = (state_reg == S_ACCEPT);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_present_reg <= 1'b0;
            image_bytes_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == odcc_pkg::CFG_DISK_PRESENT)
            begin
                disk_present_reg <= cfg_data[0];
            end
            else
            begin
                image_bytes_reg <= cfg_data;
            end
        end
    end

    // Command decode: reply length and whether the command is known.
    always_comb
    begin
        known     = 1'b1;
        reply_len = 4'd1;
        id_reply  = 1'b0;
        case (in_ch.write_value)
            odcc_pkg::CMD_NOP, odcc_pkg::CMD_SETMODE, odcc_pkg::CMD_READN,
            odcc_pkg::CMD_READS, odcc_pkg::CMD_PAUSE, odcc_pkg::CMD_INIT: reply_len = 4'd1;
            odcc_pkg::CMD_GETID, odcc_pkg::CMD_GETID2:
            begin
                reply_len = 4'd5;
                id_reply  = 1'b1;
            end
            odcc_pkg::CMD_GETPARAM: reply_len = 4'd2;
            odcc_pkg::CMD_GETTN:    reply_len = 4'd8;
            odcc_pkg::CMD_GETTD:    reply_len = 4'd5;
            odcc_pkg::CMD_TEST:
                reply_len = (param_count_reg != '0 && param0_reg == odcc_pkg::TEST_PARAM)
                            ? 4'd5 : 4'd1;
            default: known = 1'b0;
        endcase
    end

    assign resp_load = accept && in_ch.mode == odcc_pkg::MODE_WRITE &&
                       in_ch.reg_offset == odcc_pkg::OFF_CMD && known;
    assign resp_pop  = accept && in_ch.mode == odcc_pkg::MODE_READ &&
                       in_ch.reg_offset == odcc_pkg::OFF_CMD;

    odcc_resp_fifo #(.RESP_DEPTH(RESP_DEPTH)) u_resp (
        .clk, .rst_n, .load(resp_load), .reply_len, .id_reply,
        .pop(resp_pop), .avail(resp_avail), .rd_data(resp_rd)
    );

    // Sector buffer access.
    always_comb
    begin
        breq.wr_en   = accept && in_ch.mode == odcc_pkg::MODE_DISK;
        breq.wr_addr = fill_pos_reg;
        breq.wr_data = in_ch.disk_byte;
        breq.rd_en   = accept && in_ch.mode == odcc_pkg::MODE_READ &&
                       in_ch.reg_offset == odcc_pkg::OFF_DATA;
        breq.rd_addr = buf_read_pos_reg[BW-1:0];
    end

    odcc_sector_buf u_buf (.clk, .req(breq), .rd_data(buf_rd));

    // Tick arithmetic and range check.
    assign accum_sum = accum_reg + 32'(in_ch.tick_cycles);
    assign base      = 44'(sector_reg) * 44'(odcc_pkg::RAW_BYTES);
    assign in_range  = (base + 44'(odcc_pkg::USER_BYTES)) <= 44'(image_bytes_reg);
    assign tick_due  = accum_sum >= 32'(TICK_PERIOD);
    assign fetch_req = tick_due && drive_reg == odcc_pkg::DRV_READING &&
                       disk_present_reg && in_range;
    assign buf_avail = buf_full_reg &&
                       buf_read_pos_reg < (BW+1)'(odcc_pkg::USER_BYTES);

    // Result of the item on the input and where its read data comes from.
    always_comb
    begin
        res_next = '0;
        src_next = SRC_NONE;
        case (in_ch.mode)
            odcc_pkg::MODE_READ:
            begin
                case (in_ch.reg_offset)
                    odcc_pkg::OFF_INDEX: res_next.read_data = 8'(index_reg);
                    odcc_pkg::OFF_CMD:
                    begin
                        if (resp_avail)
                        begin
                            src_next = SRC_RESP;
                        end
                    end
                    odcc_pkg::OFF_DATA:
                    begin
                        if (buf_avail)
                        begin
                            src_next = SRC_BUF;
                        end
                    end
                    default: res_next.read_data = 8'(irq_flag_reg);
                endcase
            end
            odcc_pkg::MODE_WRITE:
            begin
                if (in_ch.reg_offset == odcc_pkg::OFF_CMD && known)
                begin
                    res_next.irq_request = 1'b1;
                end
            end
            odcc_pkg::MODE_TICK:
            begin
                if (fetch_req)
                begin
                    res_next.fetch_valid  = 1'b1;
                    res_next.fetch_offset = base[31:0] + 32'(odcc_pkg::DATA_SKIP);
                end
            end
            default: ;
        endcase
    end

    // Main sequencer with state updates and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_ACCEPT;
            index_reg        <= '0;
            param0_reg       <= '0;
            param_count_reg  <= '0;
            irq_flag_reg     <= '0;
            drive_reg        <= odcc_pkg::DRV_IDLE;
            sector_reg       <= '0;
            accum_reg        <= '0;
            buf_full_reg     <= 1'b0;
            buf_read_pos_reg <= '0;
            fill_pos_reg     <= '0;
            src_reg          <= SRC_NONE;
            res_reg          <= '0;
        end
        else
        begin
            case (state_reg)
                S_ACCEPT:
                begin
                    if (accept)
                    begin
                        res_reg   <= res_next;
                        src_reg   <= src_next;
                        state_reg <= S_MEM;
                        case (in_ch.mode)
                            odcc_pkg::MODE_READ:
                            begin
                                if (in_ch.reg_offset == odcc_pkg::OFF_DATA && buf_avail)
                                begin
                                    buf_read_pos_reg <= buf_read_pos_reg + (BW+1)'(1);
                                end
                            end
                            odcc_pkg::MODE_WRITE:
                            begin
                                case (in_ch.reg_offset)
                                    odcc_pkg::OFF_INDEX: index_reg <= in_ch.write_value[1:0];
                                    odcc_pkg::OFF_CMD:
                                    begin
                                        if (known)
                                        begin
                                            irq_flag_reg <= odcc_pkg::IRQ_ACK;
                                            if (in_ch.write_value == odcc_pkg::CMD_READN ||
                                                in_ch.write_value == odcc_pkg::CMD_READS)
                                            begin
                                                drive_reg <= odcc_pkg::DRV_READING;
                                            end
                                            else if (in_ch.write_value == odcc_pkg::CMD_PAUSE)
                                            begin
                                                drive_reg <= odcc_pkg::DRV_PAUSED;
                                            end
                                            else if (in_ch.write_value == odcc_pkg::CMD_INIT)
                                            begin
                                                drive_reg  <= odcc_pkg::DRV_IDLE;
                                                sector_reg <= '0;
                                            end
                                        end
                                    end
                                    odcc_pkg::OFF_DATA:
                                    begin
                                        if (param_count_reg < PCW'(PARAM_DEPTH))
                                        begin
                                            if (param_count_reg == '0)
                                            begin
                                                param0_reg <= in_ch.write_value;
                                            end
                                            param_count_reg <= param_count_reg + PCW'(1);
                                        end
                                    end
                                    default:
                                    begin
                                        if (index_reg == 2'd1)
                                        begin
                                            irq_flag_reg <= irq_flag_reg &
                                                ~(in_ch.write_value[4:0] & odcc_pkg::IRQ_MASK);
                                        end
                                    end
                                endcase
                            end
                            odcc_pkg::MODE_TICK:
                            begin
                                if (tick_due)
                                begin
                                    accum_reg <= accum_sum - 32'(TICK_PERIOD);
                                    if (drive_reg == odcc_pkg::DRV_READING && disk_present_reg)
                                    begin
                                        if (in_range)
                                        begin
                                            buf_full_reg     <= 1'b1;
                                            buf_read_pos_reg <= '0;
                                            fill_pos_reg     <= '0;
                                        end
                                        sector_reg <= sector_reg + 32'd1;
                                    end
                                end
                                else
                                begin
                                    accum_reg <= accum_sum;
                                end
                            end
                            default: fill_pos_reg <= fill_pos_reg + BW'(1);
                        endcase
                    end
                end
                S_MEM:
                begin
                    if (src_reg == SRC_RESP)
                    begin
                        res_reg.read_data <= resp_rd;
                    end
                    else if (src_reg == SRC_BUF)
                    begin
                        res_reg.read_data <= buf_rd;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        state_reg <= S_ACCEPT;
                    end
                end
                default: state_reg <= S_ACCEPT;
            endcase
        end
    end

    assign out_ch.valid        = (state_reg == S_OUT);
    assign out_ch.read_data    = res_reg.read_data;
    assign out_ch.irq_request  = res_reg.irq_request;
    assign out_ch.fetch_valid  = res_reg.fetch_valid;
    assign out_ch.fetch_offset = res_reg.fetch_offset;

    // An accepted item moves on to the memory read state.
    `ODC_ASSERT_NEXT(a_item_to_mem, clk, rst_n, accept, state_reg == S_MEM, "item lost")
    // A command interrupt always leaves the flag at the acknowledge value.
    `ODC_ASSERT_IMP(a_irq_flag, clk, rst_n, out_ch.valid && out_ch.irq_request,
        irq_flag_reg == odcc_pkg::IRQ_ACK, "irq flag not set")
    // A fetch never happens without a loaded disk.
    `ODC_ASSERT_IMP(a_fetch_disk, clk, rst_n, out_ch.valid && out_ch.fetch_valid,
        disk_present_reg, "fetch without disk")
    // The buffer read position never passes one sector.
    `ODC_ASSERT_IMP(a_buf_pos, clk, rst_n, 1'b1,
        buf_read_pos_reg <= (BW+1)'(odcc_pkg::USER_BYTES), "buffer overrun")
endmodule

// File: rtl/core/odcc_sector_buf.sv
// Sector buffer memory with one write and one registered read port.
`timescale 1ns / 1ps
module odcc_sector_buf (
    input  logic              clk,
    input  odcc_pkg::buf_req_t req,
    output logic [7:0]        rd_data
);
    logic [7:0] mem [odcc_pkg::USER_BYTES];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule

// File: rtl/core/odcc_resp_fifo.sv
// Response FIFO memory; a command resets it and loads its reply bytes.
`timescale 1ns / 1ps
module odcc_resp_fifo #(
    parameter int RESP_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [3:0]                   reply_len,
    input  logic                         id_reply,
    input  logic                         pop,
    output logic                         avail,
    output logic [7:0]                   rd_data
);
    localparam int PW = $clog2(RESP_DEPTH + 1);
    localparam int AW = $clog2(RESP_DEPTH);

    logic [PW-1:0] count_reg, read_pos_reg;
    logic [7:0]    mem [RESP_DEPTH];
    logic [PW-1:0] len_ext;

    // Replies hold at most eight bytes but the depth caps them.
    always_comb
    begin
        len_ext = PW'(reply_len);
        if (len_ext > PW'(RESP_DEPTH))
        begin
            len_ext = PW'(RESP_DEPTH);
        end
    end

    assign avail = read_pos_reg < count_reg;

    // Count and read pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            read_pos_reg <= '0;
        end
        else if (load)
        begin
            count_reg    <= len_ext;
            read_pos_reg <= '0;
        end
        else if (pop && avail)
        begin
            read_pos_reg <= read_pos_reg + PW'(1);
        end
    end

    // Reply bytes are written in one pass; only entries below the count are read.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < RESP_DEPTH; i++)
            begin
                mem[i] <= (i == 0) ? odcc_pkg::STATUS_BYTE :
                          (i == 2 && id_reply) ? odcc_pkg::ID_BYTE : 8'h00;
            end
        end
        if (pop && avail)
        begin
            rd_data <= mem[read_pos_reg[AW-1:0]];
        end
        else
        begin
            rd_data <= 8'h00;
        end
    end
endmodule

// File: test/drive_response_checker.sv
// Checker that predicts and compares the drive controller's results.
`timescale 1ns / 1ps
module drive_response_checker
    import odcc_pkg::*;
#(
    parameter int RESP_DEPTH  = 16,
    parameter int PARAM_DEPTH = 16,
    parameter int TICK_PERIOD = 1000
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [31:0] cfg_data,
    odcc_in_if   in_ch,
    odcc_out_if  out_ch,
    output int   fail_count,
    output int   pending
);
    // Configuration as the block should hold it.
    logic        disk_loaded;
    logic [31:0] image_size;

    // Predicted controller state.
    logic [1:0]   index_sel;
    logic [7:0]   param_store [PARAM_DEPTH];
    int           param_fill;
    logic [7:0]   reply_store [RESP_DEPTH];
    int           reply_fill;
    int           reply_pos;
    logic [4:0]   irq_bits;
    drive_state_t drive_mode;
    logic [31:0]  sector_num;
    logic [31:0]  cycle_total;
    logic [7:0]   sector_data [USER_BYTES];
    logic         sector_written [USER_BYTES];
    int           data_size;
    int           data_pos;
    int           fill_pos;

    // Low when the last predicted read hit a buffer entry never written.
    logic         data_known;

    result_t awaited_results[$];
    logic    awaited_known[$];

    // Append one byte to the reply unless it is full.
    function automatic void push_reply(logic [7:0] b);
        if (reply_fill < RESP_DEPTH)
        begin
            reply_store[reply_fill] = b;
            reply_fill++;
        end
    endfunction

    // Decode a command byte; returns 1 when it raises the interrupt.
    function automatic logic run_drive_command(logic [7:0] cmd);
        int zeros;
        zeros = 0;
        case (cmd)
            CMD_NOP, CMD_SETMODE, CMD_READN, CMD_READS, CMD_PAUSE, CMD_INIT,
            CMD_GETID, CMD_GETID2, CMD_GETPARAM, CMD_GETTN, CMD_GETTD, CMD_TEST: ;
            default: return 1'b0;
        endcase
        if (cmd == CMD_READN || cmd == CMD_READS)
            drive_mode = DRV_READING;
        else if (cmd == CMD_PAUSE)
            drive_mode = DRV_PAUSED;
        else if (cmd == CMD_INIT)
        begin
            drive_mode = DRV_IDLE;
            sector_num = '0;
        end
        reply_fill = 0;
        reply_pos  = 0;
        push_reply(STATUS_BYTE);
        if (cmd == CMD_GETID || cmd == CMD_GETID2)
        begin
            push_reply(8'h00);
            push_reply(ID_BYTE);
            zeros = 2;
        end
        else if (cmd == CMD_GETPARAM)
            zeros = 1;
        else if (cmd == CMD_GETTN)
            zeros = 7;
        else if (cmd == CMD_GETTD)
            zeros = 4;
        else if (cmd == CMD_TEST && param_fill > 0 && param_store[0] == TEST_PARAM)
            zeros = 4;
        for (int i = 0; i < zeros; i++)
            push_reply(8'h00);
        irq_bits = IRQ_ACK;
        return 1'b1;
    endfunction

    // Work out the result of one item and advance the predicted state.
    function automatic result_t predict_drive_result(logic [1:0] mode, logic [1:0] offset,
                                                     logic [7:0] value, logic [15:0] ticks,
                                                     logic [7:0] dbyte);
        result_t     r;
        logic [63:0] base;
        r = '0;
        data_known = 1'b1;
        case (mode)
            MODE_READ:
                case (offset)
                    OFF_INDEX: r.read_data = {6'd0, index_sel};
                    OFF_CMD:
                        if (reply_pos < reply_fill)
                        begin
                            r.read_data = reply_store[reply_pos];
                            reply_pos++;
                        end
                    OFF_DATA:
                        if (data_pos < data_size)
                        begin
                            r.read_data = sector_data[data_pos % USER_BYTES];
                            data_known  = sector_written[data_pos % USER_BYTES];
                            data_pos++;
                        end
                    default: r.read_data = {3'd0, irq_bits};
                endcase
            MODE_WRITE:
                case (offset)
                    OFF_INDEX: index_sel = value[1:0];
                    OFF_CMD:   r.irq_request = run_drive_command(value);
                    OFF_DATA:
                        if (param_fill < PARAM_DEPTH)
                        begin
                            param_store[param_fill] = value;
                            param_fill++;
                        end
                    default:
                        if (index_sel == 2'd1)
                            irq_bits = irq_bits & ~(value[4:0] & IRQ_MASK);
                endcase
            MODE_TICK:
            begin
                cycle_total = cycle_total + 32'(ticks);
                if (cycle_total >= 32'(TICK_PERIOD))
                begin
                    cycle_total = cycle_total - 32'(TICK_PERIOD);
                    if (drive_mode == DRV_READING && disk_loaded)
                    begin
                        base = 64'(sector_num) * 64'(RAW_BYTES);
                        if (base + 64'(USER_BYTES) <= 64'(image_size))
                        begin
                            r.fetch_valid  = 1'b1;
                            r.fetch_offset = 32'(base + 64'(DATA_SKIP));
                            data_size = USER_BYTES;
                            data_pos  = 0;
                            fill_pos  = 0;
                        end
                        sector_num = sector_num + 32'd1;
                    end
                end
            end
            default:
            begin
                sector_data[fill_pos]    = dbyte;
                sector_written[fill_pos] = 1'b1;
                fill_pos = (fill_pos + 1) % USER_BYTES;
            end
        endcase
        return r;
    endfunction

    // Compare each result transfer, then predict each accepted item.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got, want;
        logic    want_known;
        if (!rst_n)
        begin
            disk_loaded = 1'b0;
            image_size  = '0;
            index_sel   = '0;
            param_fill  = 0;
            reply_fill  = 0;
            reply_pos   = 0;
            irq_bits    = '0;
            drive_mode  = DRV_IDLE;
            sector_num  = '0;
            cycle_total = '0;
            data_size   = 0;
            data_pos    = 0;
            fill_pos    = 0;
            data_known  = 1'b1;
            for (int i = 0; i < PARAM_DEPTH; i++)
                param_store[i] = '0;
            for (int i = 0; i < RESP_DEPTH; i++)
                reply_store[i] = '0;
            for (int i = 0; i < USER_BYTES; i++)
            begin
                sector_data[i]    = '0;
                sector_written[i] = 1'b0;
            end
            awaited_results.delete();
            awaited_known.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.read_data    = out_ch.read_data;
                got.irq_request  = out_ch.irq_request;
                got.fetch_valid  = out_ch.fetch_valid;
                got.fetch_offset = out_ch.fetch_offset;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected: %h", $realtime, got);
                    fail_count++;
                end
                else
                begin
                    want       = awaited_results.pop_front();
                    want_known = awaited_known.pop_front();
                    // A buffer entry never written holds no defined byte.
                    if (want_known && got.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $realtime, want.read_data, got.read_data);
                        fail_count++;
                    end
                    if (got.irq_request !== want.irq_request)
                    begin
                        $display("%0t: irq_request expected %b actual %b",
                                 $realtime, want.irq_request, got.irq_request);
                        fail_count++;
                    end
                    if (got.fetch_valid !== want.fetch_valid)
                    begin
                        $display("%0t: fetch_valid expected %b actual %b",
                                 $realtime, want.fetch_valid, got.fetch_valid);
                        fail_count++;
                    end
                    if (got.fetch_offset !== want.fetch_offset)
                    begin
                        $display("%0t: fetch_offset expected %h actual %h",
                                 $realtime, want.fetch_offset, got.fetch_offset);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_DISK_PRESENT)
                    disk_loaded = cfg_data[0];
                else
                    image_size = cfg_data;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                awaited_results.push_back(predict_drive_result(in_ch.mode, in_ch.reg_offset,
                                                               in_ch.write_value,
                                                               in_ch.tick_cycles,
                                                               in_ch.disk_byte));
                awaited_known.push_back(data_known);
            end
        end
        pending = awaited_results.size();
    end
endmodule

// File: test/optical_drive_command_controller_top_tb.sv
// Stimulus and verdict for the optical drive command controller.
`timescale 1ns / 1ps
module optical_drive_command_controller_top_tb;
    import odcc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_idle;
    int          phase_items;
    int          hold_asks;
    int          hold_done;
    int          hold_left;
    int          cycle_count;

    odcc_in_if  in_ch ();
    odcc_out_if out_ch ();

    optical_drive_command_controller_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    drive_response_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock with a 2 ns period.
    initial
        clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_asks != hold_done)
        begin
            hold_done    <= hold_asks;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Run limit.
    always @(posedge clk)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item and wait for its transfer; valid is left high and drops only while the sender idles.
    task automatic send_item(logic [1:0] mode, logic [1:0] offset, logic [7:0] value,
                             logic [15:0] ticks, logic [7:0] dbyte);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.reg_offset  <= offset;
        in_ch.write_value <= value;
        in_ch.tick_cycles <= ticks;
        in_ch.disk_byte   <= dbyte;
        do
            @(posedge clk);
        while (!in_ch.ready);
        phase_items++;
    endtask

    task automatic reg_read(logic [1:0] offset);
        send_item(MODE_READ, offset, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic reg_write(logic [1:0] offset, logic [7:0] value);
        send_item(MODE_WRITE, offset, value, 16'($urandom), 8'($urandom));
    endtask

    task automatic tick(logic [15:0] ticks);
        send_item(MODE_TICK, 2'($urandom), 8'($urandom), ticks, 8'($urandom));
    endtask

    task automatic disk_byte(logic [7:0] b);
        send_item(MODE_DISK, 2'($urandom), 8'($urandom), 16'($urandom), b);
    endtask

    // Wait until every expected result has arrived and the block has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic set_disk(logic present, logic [31:0] image_bytes);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DISK_PRESENT;
        cfg_data  <= {31'd0, present};
        @(posedge clk);
        cfg_index <= CFG_IMAGE_BYTES;
        cfg_data  <= image_bytes;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Parameters, a command (sometimes unknown), reply and flag reads, sometimes index and flag writes.
    task automatic command_sequence();
        logic [7:0] cmds [12];
        logic [7:0] cmd;
        cmds = '{CMD_NOP, CMD_SETMODE, CMD_GETID, CMD_GETID2, CMD_READN, CMD_READS,
                 CMD_PAUSE, CMD_INIT, CMD_GETPARAM, CMD_GETTN, CMD_GETTD, CMD_TEST};
        repeat ($urandom_range(2))
            reg_write(OFF_DATA, ($urandom_range(1) != 0) ? TEST_PARAM : 8'($urandom));
        cmd = ($urandom_range(5) == 0) ? 8'($urandom) : cmds[$urandom_range(11)];
        reg_write(OFF_CMD, cmd);
        repeat ($urandom_range(10))
            reg_read(OFF_CMD);
        reg_read(OFF_IRQ);
        if ($urandom_range(1) != 0)
        begin
            reg_write(OFF_INDEX, 8'($urandom_range(3)));
            reg_write(OFF_IRQ, 8'($urandom));
            reg_read(OFF_IRQ);
        end
    endtask

    // Start reading, tick toward a fetch, deliver some bytes and read them back, then sometimes pause or init.
    task automatic sector_sequence();
        reg_write(OFF_CMD, ($urandom_range(1) != 0) ? CMD_READN : CMD_READS);
        repeat ($urandom_range(1, 3))
            tick(16'($urandom_range(700, 1300)));
        repeat ($urandom_range(30))
            disk_byte(8'($urandom));
        repeat ($urandom_range(30))
            reg_read(OFF_DATA);
        if ($urandom_range(3) == 0)
            reg_write(OFF_CMD, ($urandom_range(1) != 0) ? CMD_PAUSE : CMD_INIT);
    endtask

    // One random phase of mostly well-formed sequences and some noise.
    task automatic random_phase(logic with_hold);
        logic held;
        held = 1'b0;
        phase_items = 0;
        while (phase_items < PHASE_ITEMS)
        begin
            if (with_hold && !held && phase_items > 100)
            begin
                hold_asks++;
                held = 1'b1;
            end
            case ($urandom_range(9))
                0, 1, 2, 3: command_sequence();
                4, 5, 6:    sector_sequence();
                default:
                    repeat ($urandom_range(1, 4))
                        send_item(2'($urandom), 2'($urandom), 8'($urandom),
                                  16'($urandom), 8'($urandom));
            endcase
        end
        drain();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_DISK_PRESENT;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= MODE_READ;
        in_ch.reg_offset  <= OFF_INDEX;
        in_ch.write_value <= '0;
        in_ch.tick_cycles <= '0;
        in_ch.disk_byte   <= '0;
        send_idle          = 0;
        recv_idle          = 0;
        hold_asks          = 0;
        phase_items        = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Four sectors fit in this image.
        set_disk(1'b1, 32'(3 * 2352 + 2048));

        // Directed: every register on empty FIFOs, then a set of commands, unknown bytes among them.
        reg_read(OFF_INDEX);
        reg_read(OFF_CMD);
        reg_read(OFF_DATA);
        reg_read(OFF_IRQ);
        reg_write(OFF_INDEX, 8'hFF);
        reg_read(OFF_INDEX);
        reg_write(OFF_IRQ, 8'hFF);
        reg_write(OFF_CMD, 8'h00);
        reg_write(OFF_CMD, 8'hFF);
        reg_write(OFF_CMD, CMD_TEST);
        reg_write(OFF_DATA, TEST_PARAM);
        reg_write(OFF_CMD, CMD_TEST);
        repeat (6) reg_read(OFF_CMD);
        reg_write(OFF_CMD, CMD_GETID);
        reg_write(OFF_CMD, CMD_GETTN);
        reg_read(OFF_IRQ);
        reg_write(OFF_INDEX, 8'h01);
        reg_write(OFF_IRQ, 8'h01);
        reg_read(OFF_IRQ);
        reg_write(OFF_CMD, CMD_READN);
        tick(16'hFFFF);
        tick(16'h0000);
        reg_write(OFF_CMD, CMD_PAUSE);
        tick(16'd1000);
        reg_write(OFF_CMD, CMD_INIT);

        // Two bytes at the start of the buffer, read straight back.
        disk_byte(8'h00);
        disk_byte(8'hFF);
        reg_read(OFF_DATA);
        reg_read(OFF_DATA);
        drain();

        // Sender idles less than the receiver.
        send_idle = 27;
        recv_idle = 70;
        random_phase(1'b0);

        // No disk, then a disk with an empty image.
        set_disk(1'b0, 32'hFFFF_FFFF);
        send_idle = 70;
        recv_idle = 27;
        random_phase(1'b0);
        set_disk(1'b1, 32'd0);
        send_idle = 0;
        recv_idle = 0;
        repeat (12) sector_sequence();
        drain();

        // Largest image, no idling, with one long receiver hold-off.
        set_disk(1'b1, 32'hFFFF_FFFF);
        random_phase(1'b1);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
